// ----- hdl/rrf_pkg.sv -----
package rrf_pkg;

    localparam int MaxEntries = 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);
    localparam logic [6:0] RankLimit = 7'd64;
    localparam logic [6:0] RankAbsent = 7'h7F;
    localparam logic [32:0] ScoreMax = 33'h1_FFFF_FFFF;

    localparam logic [1:0] KIND_KEYWORD = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    // Entry as held in the store; 143 bits.
    typedef struct packed {
        logic [31:0] sim;
        logic [6:0]  vrank;
        logic [6:0]  krank;
        logic [32:0] score;
        logic [63:0] id;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            div_start;
        logic            rd_en;
        logic [IdxW-1:0] rd_addr;
        logic            wr_en;
        logic [IdxW-1:0] wr_addr;
        logic            wr_sel_b;  // write held entry b instead of new/updated a
        logic            wr_merge;  // write a merged with incoming score/rank/sim
        logic            wr_new;    // write the incoming entry
        logic            load_a;
        logic            load_b;
        logic            latch_item;
        logic            out_load;
        logic            out_empty;
        logic            out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic        div_done;
        logic        id_match;   // rd data id equals latched id
        logic        b_greater;  // rd data score greater than held a
    } dp_stat_t;

endpackage

// ----- hdl/rrf_div.sv -----
module rrf_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);
    import rrf_pkg::*;

    // Restoring divider for 2^32 / divisor, one quotient bit per cycle.
    logic [32:0] quot_reg, quot_next;
    logic [17:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [17:0] trial;
    logic        num_bit;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvs_next  = dvs_reg;
        num_bit   = (cnt_reg == 6'd32);
        trial     = {rem_reg[16:0], num_bit};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            quot_next = '0;
            dvs_next  = (divisor == 17'd0) ? 17'd1 : divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[31:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[31:0], 1'b0};
            end
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

// ----- hdl/rrf_datapath.sv -----
module rrf_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrf_pkg::dp_cmd_t     cmd,
    output rrf_pkg::dp_stat_t    stat,
    input  logic [63:0]          in_id,
    input  logic [31:0]          in_sim,
    input  logic [6:0]           rank,
    input  logic                 is_vector,
    input  logic [9:0]           rank_offset,
    input  logic [1:0]           err,
    output logic [151:0]         out_data,
    output logic                 out_last
);
    import rrf_pkg::*;

    entry_t      mem [MaxEntries];
    entry_t      rd_reg;
    entry_t      a_reg, b_reg;
    logic [63:0] id_reg;
    logic [31:0] sim_reg;
    logic [6:0]  rank_reg;
    logic        vec_reg;
    logic [32:0] score;
    logic        div_done;
    logic [33:0] sum;
    entry_t      wr_data, oe;
    logic [151:0] od_reg;
    logic        ol_reg;

    rrf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  ({7'd0, rank_offset} + {10'd0, rank}),
        .done     (div_done),
        .quotient (score)
    );

    assign sum = {1'b0, rd_reg.score} + {1'b0, score};

    always_comb begin
        wr_data = '0;
        if (cmd.wr_sel_b) begin
            wr_data = b_reg;
        end else if (cmd.wr_merge) begin
            wr_data       = rd_reg;
            wr_data.score = sum[33] ? ScoreMax : sum[32:0];
            wr_data.vrank = rank_reg;
            wr_data.sim   = sim_reg;
        end else if (cmd.wr_new) begin
            wr_data.id    = id_reg;
            wr_data.score = score;
            wr_data.krank = vec_reg ? RankAbsent : rank_reg;
            wr_data.vrank = vec_reg ? rank_reg : RankAbsent;
            wr_data.sim   = vec_reg ? sim_reg : 32'd0;
        end else begin
            wr_data = a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
        if (cmd.rd_en) rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            id_reg   <= in_id;
            sim_reg  <= in_sim;
            rank_reg <= rank;
            vec_reg  <= is_vector;
        end
        if (cmd.load_a) a_reg <= rd_reg;
        if (cmd.load_b) b_reg <= rd_reg;
    end

    always_comb begin
        oe = rd_reg;
        if (cmd.out_empty) begin
            oe       = '0;
            oe.krank = RankAbsent;
            oe.vrank = RankAbsent;
        end
    end

    // tdata layout: valid, id, score, krank, vrank, sim, status, padding.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            od_reg <= {6'd0, err, oe.sim, oe.vrank, oe.krank, oe.score, oe.id,
                       !cmd.out_empty};
            ol_reg <= cmd.out_last;
        end
    end

    assign out_data       = od_reg;
    assign out_last       = ol_reg;
    assign stat.div_done  = div_done;
    assign stat.id_match  = (rd_reg.id == id_reg);
    assign stat.b_greater = (rd_reg.score > a_reg.score);
endmodule

// ----- hdl/rrf_ctrl.sv -----
module rrf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           kind,
    input  logic                 m_ready,
    output logic                 m_valid,
    output rrf_pkg::dp_cmd_t     cmd,
    input  rrf_pkg::dp_stat_t    stat,
    output logic [6:0]           rank,
    output logic                 is_vector,
    output logic [1:0]           err
);
    import rrf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIV    = 11'b00000000010,
        S_SRCH   = 11'b00000000100,
        S_CMP    = 11'b00000001000,
        S_SI_RD  = 11'b00000010000,
        S_SI_LD  = 11'b00000100000,
        S_SJ_RD  = 11'b00001000000,
        S_SJ_CMP = 11'b00010000000,
        S_SW2    = 11'b00100000000,
        S_OUT_RD = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [6:0]      kcnt_reg, kcnt_next, vcnt_reg, vcnt_next;
    logic            phase_reg, phase_next;
    logic [1:0]      err_reg, err_next;
    logic [CntW-1:0] i_reg, i_next, j_reg, j_next;
    logic            mv_reg, mv_next;
    logic            vec_reg, vec_next;
    logic            acc;
    logic [1:0]      err_flag1, err_flag2;

    assign acc       = s_valid && s_ready;
    assign err_flag1 = (err_reg == ST_OK) ? ST_DROPPED : err_reg;
    assign err_flag2 = (err_reg == ST_OK) ? ST_ORDER : err_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        kcnt_next  = kcnt_reg;
        vcnt_next  = vcnt_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mv_next    = mv_reg;
        vec_next   = vec_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        rank       = (kind == KIND_VECTOR) ? vcnt_reg : kcnt_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = !mv_reg;
                if (acc) begin
                    case (kind)
                        KIND_KEYWORD: begin
                            if (phase_reg) begin
                                err_next = err_flag2;
                            end else if (kcnt_reg >= RankLimit) begin
                                err_next = err_flag1;
                            end else begin
                                kcnt_next = kcnt_reg + 7'd1;
                                if (count_reg == CntW'(MaxEntries)) begin
                                    err_next = err_flag1;
                                end else begin
                                    cmd.latch_item = 1'b1;
                                    cmd.div_start  = 1'b1;
                                    vec_next       = 1'b0;
                                    state_next     = S_DIV;
                                end
                            end
                        end
                        KIND_VECTOR: begin
                            phase_next = 1'b1;
                            if (vcnt_reg >= RankLimit) begin
                                err_next = err_flag1;
                            end else begin
                                vcnt_next      = vcnt_reg + 7'd1;
                                cmd.latch_item = 1'b1;
                                cmd.div_start  = 1'b1;
                                vec_next       = 1'b1;
                                state_next     = S_DIV;
                            end
                        end
                        KIND_END: begin
                            i_next = '0;
                            if (count_reg == '0) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = S_SI_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                i_next = '0;
                if (stat.div_done) begin
                    if (vec_reg && count_reg != '0) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        state_next  = S_SRCH;
                    end else begin
                        state_next = S_CMP;
                    end
                end
            end
            S_SRCH: state_next = S_CMP;
            S_CMP: begin
                if (vec_reg && i_reg < count_reg && stat.id_match) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_addr  = i_reg[IdxW-1:0];
                    cmd.wr_merge = 1'b1;
                    state_next   = S_IDLE;
                end else if (vec_reg && i_reg + 1'b1 < count_reg) begin
                    i_next      = i_reg + 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = IdxW'(i_reg + 1'b1);
                    state_next  = S_SRCH;
                end else begin
                    if (count_reg == CntW'(MaxEntries)) begin
                        err_next = err_flag1;
                    end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = count_reg[IdxW-1:0];
                        cmd.wr_new  = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SI_RD: begin
                if (i_reg + 1'b1 >= count_reg) begin
                    i_next      = '0;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = '0;
                    state_next  = S_OUT_RD;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_reg[IdxW-1:0];
                    state_next  = S_SI_LD;
                end
            end
            S_SI_LD: begin
                cmd.load_a  = 1'b1;
                j_next      = i_reg + 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = IdxW'(i_reg + 1'b1);
                state_next  = S_SJ_CMP;
            end
            S_SJ_RD: state_next = S_SJ_CMP;
            S_SJ_CMP: begin
                if (stat.b_greater) begin
                    // Swap: entry j goes to slot i, held a goes to slot j.
                    cmd.load_b  = 1'b1;
                    cmd.load_a  = 1'b1;
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = j_reg[IdxW-1:0];
                    state_next  = S_SW2;
                end else if (j_reg + 1'b1 < count_reg) begin
                    j_next      = j_reg + 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = IdxW'(j_reg + 1'b1);
                    state_next  = S_SJ_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SI_RD;
                end
            end
            S_SW2: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = i_reg[IdxW-1:0];
                cmd.wr_sel_b = 1'b1;
                if (j_reg + 1'b1 < count_reg) begin
                    j_next      = j_reg + 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = IdxW'(j_reg + 1'b1);
                    state_next  = S_SJ_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SI_RD;
                end
            end
            S_OUT_RD: state_next = S_OUT;
            S_OUT: begin
                if (!mv_next) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_empty = (count_reg == '0);
                    cmd.out_last  = (i_reg + 1'b1 >= count_reg);
                    mv_next       = 1'b1;
                    if (i_reg + 1'b1 >= count_reg) begin
                        count_next = '0;
                        kcnt_next  = '0;
                        vcnt_next  = '0;
                        phase_next = 1'b0;
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end else begin
                        i_next      = i_reg + 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IdxW'(i_reg + 1'b1);
                        state_next  = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            kcnt_reg  <= '0;
            vcnt_reg  <= '0;
            phase_reg <= 1'b0;
            err_reg   <= ST_OK;
            i_reg     <= '0;
            j_reg     <= '0;
            mv_reg    <= 1'b0;
            vec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            kcnt_reg  <= kcnt_next;
            vcnt_reg  <= vcnt_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            mv_reg    <= mv_next;
            vec_reg   <= vec_next;
        end
    end

    assign m_valid   = mv_reg;
    assign is_vector = (kind == KIND_VECTOR);
    assign err       = err_reg;
endmodule

// ----- hdl/reciprocal_rank_fusion_merge.sv -----
// Channel   | Direction | Contents
// s_axis    | in        | tdata: node_id, similarity; tuser: kind
// m_axis    | out       | tdata: valid_res .. status; tlast: last
// apb       | in/out    | rank_offset at byte address 0
//
// A keyword item's score is formed by the bit-serial divider as
// floor(2^32/(k+rank)). A vector item adds a search of the stored entries
// for a matching id. The end item runs an exchange sort over the store,
// then sends the entries out one at a time, each after the last is taken.
// Reset is synchronous and clears the counters, FSM and error state;
// the entry store needs no clearing because the fill count bounds reads.
// A stalled result holds its register; no input item is taken meanwhile.
module reciprocal_rank_fusion_merge (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // node_id[63:0], similarity[95:64]
    input  logic [1:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // valid_res[0], node_id_res[64:1], fused_score[97:65], keyword_rank[104:98],
    // vector_rank[111:105], similarity_out[143:112], status[145:144]
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rrf_pkg::*;

    logic [9:0]   rank_offset_reg;
    dp_cmd_t      cmd;
    dp_stat_t     stat;
    logic [6:0]   rank;
    logic         is_vector;
    logic [1:0]   err;
    logic [151:0] out_data;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {22'd0, rank_offset_reg} : 32'd0;

    // The offset is to be written only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_offset_reg <= 10'd60;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            rank_offset_reg <= pwdata[9:0];
        end
    end

    rrf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .kind      (s_axis_tuser),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .cmd       (cmd),
        .stat      (stat),
        .rank      (rank),
        .is_vector (is_vector),
        .err       (err)
    );

    rrf_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_id       (s_axis_tdata[63:0]),
        .in_sim      (s_axis_tdata[95:64]),
        .rank        (rank),
        .is_vector   (is_vector),
        .rank_offset (rank_offset_reg),
        .err         (err),
        .out_data    (out_data),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = out_data;
endmodule

// ----- hdl/rrf_checker.sv -----
module rrf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast)
        else $error("empty result not last");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[145:144] != 2'd3)
        else $error("bad status");
endmodule

bind reciprocal_rank_fusion_merge rrf_checker u_rrf_checker (.*);
